// ===== hdl/nwk_pkg.sv =====
// Package for the Newick tokenizer: byte constants, result kinds, error codes,
// the tokenizer state record and the per-byte classification function.
// Used by newick_tokenizer; depends on nothing else.
package nwk_pkg;

    // Byte codes of the Newick syntax.
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Error codes carried in the value field of an error result.
    localparam logic [7:0] ERR_EMPTY       = 8'd0;
    localparam logic [7:0] ERR_NO_SEMI     = 8'd1;
    localparam logic [7:0] ERR_BRACKET     = 8'd2;
    localparam logic [7:0] ERR_SECOND_TREE = 8'd3;
    localparam logic [7:0] ERR_STRAY_SEMI  = 8'd4;
    localparam logic [7:0] ERR_SPACE       = 8'd5;

    // Most results one input byte can cause.
    localparam int unsigned MAX_RES = 4;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_DELIM = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_res;

    typedef struct packed {
        logic [7:0] held_byte;
        logic       held_valid;
        logic [7:0] before_held;
        logic       before_valid;
        logic       in_quote;
        logic       quote_closed;
        logic       in_comment;
        logic       label_open;
        logic       halted;
    } t_state;

    localparam t_state STATE_RESET = '0;

    // Outcome of judging one text byte.
    typedef struct packed {
        t_state     st;
        logic       ok;
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_take;

    // Ordered list of results of one input item.
    typedef struct packed {
        t_res [MAX_RES-1:0] e;
        logic [2:0]         n;
    } t_list;

    function automatic t_list list_push(t_list l, t_res r);
        t_list o;
        o = l;
        o.e[l.n[1:0]] = r;
        o.n = l.n + 3'd1;
        return o;
    endfunction

    function automatic t_list list_push_take(t_list l, t_take t);
        t_list o;
        o = l;
        if (t.n != 2'd0) begin
            o = list_push(o, t.r0);
        end
        if (t.n == 2'd2) begin
            o = list_push(o, t.r1);
        end
        return o;
    endfunction

    // Judge one text byte c with the following byte nxt in view.
    function automatic t_take take_byte(t_state s, logic [7:0] c, logic last,
                                        logic [7:0] nxt);
        t_take t;
        logic  q;
        t    = '0;
        t.st = s;
        t.ok = 1'b1;
        q    = (c == CH_SQUOTE) || (c == CH_DQUOTE);
        if (s.in_comment) begin
            // Comment bodies are dropped up to the closing bracket.
            if (c == CH_RBRACK) begin
                t.st.in_comment = 1'b0;
            end
        end else if (q && s.quote_closed) begin
            // A doubled quote stands for one literal quote and reopens quoting.
            t.r0 = '{kind: KIND_BYTE, value: CH_SQUOTE};
            t.n  = 2'd1;
            t.st.in_quote     = 1'b1;
            t.st.quote_closed = 1'b0;
            t.st.label_open   = 1'b1;
        end else begin
            t.st.quote_closed = q;
            if (q) begin
                t.st.in_quote = !s.in_quote;
            end else if (s.in_quote) begin
                if (c == CH_LBRACK) begin
                    t.st.in_comment = 1'b1;
                end else begin
                    t.r0 = '{kind: KIND_BYTE, value: c};
                    t.n  = 2'd1;
                    t.st.label_open = 1'b1;
                end
            end else if (c inside {CH_LPAREN, CH_RPAREN, CH_COLON, CH_COMMA}) begin
                // Close the label before ')', ':' or ',' unless it follows an open paren.
                if (c != CH_LPAREN && !(s.before_valid && s.before_held == CH_LPAREN)) begin
                    t.r0 = '{kind: KIND_END, value: 8'd0};
                    t.r1 = '{kind: KIND_DELIM, value: c};
                    t.n  = 2'd2;
                    t.st.label_open = 1'b0;
                end else begin
                    t.r0 = '{kind: KIND_DELIM, value: c};
                    t.n  = 2'd1;
                end
            end else if (c == CH_LBRACK || c == CH_RBRACK) begin
                t.r0 = '{kind: KIND_ERROR, value: ERR_BRACKET};
                t.n  = 2'd1;
                t.ok = 1'b0;
                t.st.halted = 1'b1;
            end else if (c == CH_SEMI && !last) begin
                t.r0 = '{kind: KIND_ERROR,
                         value: (nxt == CH_NEWLINE) ? ERR_SECOND_TREE : ERR_STRAY_SEMI};
                t.n  = 2'd1;
                t.ok = 1'b0;
                t.st.halted = 1'b1;
            end else if ((c == CH_SPACE || c == CH_NEWLINE) && s.label_open) begin
                t.r0 = '{kind: KIND_ERROR, value: ERR_SPACE};
                t.n  = 2'd1;
                t.ok = 1'b0;
                t.st.halted = 1'b1;
            end else begin
                t.r0 = '{kind: KIND_BYTE, value: c};
                t.n  = 2'd1;
                t.st.label_open = 1'b1;
            end
        end
        return t;
    endfunction

endpackage

// ===== hdl/newick_tokenizer.sv =====
// Newick tree tokenizer top level: input register, per-byte token logic and
// a small result list that drains one result per transfer.
// Depends on nwk_pkg.
//
// Usage: Newick text enters on the slave stream one byte per transfer, with
// tlast on the last byte of a tree. Tokens leave on the master stream: tuser
// gives the kind (label byte, label end, delimiter, error), tdata the byte or
// error code, and tlast marks the last token caused by one input byte.
// One byte is held back for lookahead, so the tokens of a byte come out when
// the byte after it arrives; the final byte flushes everything.
// An accepted byte waits in the input register until the result list is free;
// then it is judged and the tokens it causes are registered in the result list.
// The result list takes the next byte in the cycle in which the last token of
// the previous byte transfers; at most four tokens come from one byte.
// After an error the block swallows all input until reset. Reset clears the
// token state, the input register and the result list. When the receiver
// stalls, the shown token holds and input is taken until the input register
// and the result list are both full.
module newick_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // [7:0] ch
    input  logic       i_s_tlast,  // final_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,  // [7:0] value
    output logic [1:0] o_m_tuser,  // [1:0] kind
    output logic       o_m_tlast   // run_last
);
    import nwk_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_fin;

    t_state     r_state;
    t_state     n_state;

    t_res [MAX_RES-1:0] r_list;
    logic [2:0] r_cnt;
    logic [1:0] r_idx;

    t_list      w_list;
    t_take      w_t1;
    t_take      w_t2;
    t_state     w_mid;
    logic       w_m_fire;
    logic       w_last_out;
    logic       w_list_free;
    logic       w_proc;

    // Handshake and drain bookkeeping.
    assign w_m_fire    = o_m_tvalid && i_m_tready;
    assign w_last_out  = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign w_list_free = (r_cnt == 3'd0) || (w_m_fire && w_last_out);
    assign w_proc      = r_in_valid && w_list_free;
    assign o_s_tready  = !r_in_valid || w_proc;

    // Token logic for the byte in the input register.
    always_comb begin
        n_state = r_state;
        w_list  = '0;
        w_t1    = take_byte(r_state, r_state.held_byte, 1'b0, r_in_ch);
        w_mid   = w_t1.st;
        w_mid.before_held  = r_state.held_byte;
        w_mid.before_valid = 1'b1;
        w_t2    = take_byte(r_state.held_valid ? w_mid : r_state, r_in_ch, 1'b1, 8'd0);
        if (r_state.halted) begin
            n_state = r_state;
        end else if (!r_in_fin) begin
            // Ordinary byte: judge the held byte, then hold this one.
            if (r_state.held_valid) begin
                w_list  = list_push_take(w_list, w_t1);
                n_state = w_t1.ok ? w_mid : w_t1.st;
            end
            n_state.held_byte  = r_in_ch;
            n_state.held_valid = 1'b1;
        end else if (r_in_ch == CH_NEWLINE) begin
            // Final newline is stripped; the held byte must be the closing ';'.
            if (!r_state.held_valid) begin
                w_list = list_push(w_list, '{kind: KIND_ERROR, value: ERR_EMPTY});
                n_state.halted = 1'b1;
            end else if (r_state.held_byte != CH_SEMI) begin
                w_list = list_push(w_list, '{kind: KIND_ERROR, value: ERR_NO_SEMI});
                n_state.halted = 1'b1;
            end else begin
                w_t1    = take_byte(r_state, r_state.held_byte, 1'b1, 8'd0);
                w_list  = list_push_take(w_list, w_t1);
                n_state = w_t1.st;
                if (w_t1.ok) begin
                    if (w_t1.st.label_open) begin
                        w_list = list_push(w_list, '{kind: KIND_END, value: 8'd0});
                    end
                    n_state = STATE_RESET;
                end
            end
        end else if (r_in_ch != CH_SEMI) begin
            w_list = list_push(w_list, '{kind: KIND_ERROR, value: ERR_NO_SEMI});
            n_state.halted = 1'b1;
        end else begin
            // Final ';': judge the held byte, then the ';' itself, then close.
            if (r_state.held_valid) begin
                w_list = list_push_take(w_list, w_t1);
            end
            if (r_state.held_valid && !w_t1.ok) begin
                n_state = w_t1.st;
            end else begin
                w_list  = list_push_take(w_list, w_t2);
                n_state = w_t2.st;
                if (w_t2.ok) begin
                    if (w_t2.st.label_open) begin
                        w_list = list_push(w_list, '{kind: KIND_END, value: 8'd0});
                    end
                    n_state = STATE_RESET;
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch  <= i_s_tdata;
            r_in_fin <= i_s_tlast;
        end
    end

    // Token state and result list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cnt   <= 3'd0;
            r_idx   <= 2'd0;
        end else if (w_proc) begin
            r_state <= n_state;
            r_cnt   <= w_list.n;
            r_idx   <= 2'd0;
        end else if (w_m_fire) begin
            if (w_last_out) begin
                r_cnt <= 3'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
        if (w_proc) begin
            r_list <= w_list.e;
        end
    end

    // Output stream.
    assign o_m_tvalid = r_cnt != 3'd0;
    assign o_m_tdata  = r_list[r_idx].value;
    assign o_m_tuser  = r_list[r_idx].kind;
    assign o_m_tlast  = w_last_out;

    // Checks.
    a_idx_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index beyond the list");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_state.halted) |=> (r_cnt == 3'd0))
        else $error("results produced while halted");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_ERROR) |-> (o_m_tlast && r_state.halted))
        else $error("error token not last or block not halted");

    a_comment_quoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_comment |-> r_state.in_quote)
        else $error("comment open outside quotes");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for newick_tokenizer: drives Newick text on the slave
// stream and compares every token on the master stream with a tokenizer model.
// Depends on nwk_pkg and newick_tokenizer.
module testbench;

    import nwk_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_ITEMS  = 24;
    localparam int unsigned DRAIN_CYCLES = 20;

    // One token as it leaves the block.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_token;

    // Styles of a generated node name.
    typedef enum logic [1:0] {
        NAME_NONE,
        NAME_PLAIN,
        NAME_QUOTED,
        NAME_NUMBER
    } t_name_style;

    // Tokenizer model plus the queue of tokens still owed by the block.
    class newick_token_checker;
        t_token      pending[$];
        t_token      step_tokens[$];
        int unsigned mismatches;
        logic [7:0]  held;
        bit          held_ok;
        logic [7:0]  prev;
        bit          prev_ok;
        bit          quoting;
        bit          quote_just_closed;
        bit          commenting;
        bit          label_started;
        bit          stopped;

        function new();
            clear_text();
            mismatches = 0;
        endfunction

        function void clear_text();
            held              = 8'h00;
            held_ok           = 1'b0;
            prev              = 8'h00;
            prev_ok           = 1'b0;
            quoting           = 1'b0;
            quote_just_closed = 1'b0;
            commenting        = 1'b0;
            label_started     = 1'b0;
            stopped           = 1'b0;
        endfunction

        function void add(t_kind kind, logic [7:0] value);
            t_token t;
            t.kind  = kind;
            t.value = value;
            t.last  = 1'b0;
            step_tokens = {step_tokens, t};
        endfunction

        function void raise_error(logic [7:0] code);
            add(KIND_ERROR, code);
            stopped = 1'b1;
        endfunction

        // Judge one text byte with the byte after it in view; 0 on an error.
        function bit judge(logic [7:0] c, bit at_end, logic [7:0] nxt);
            bit q;
            if (commenting) begin
                if (c == CH_RBRACK) begin
                    commenting = 1'b0;
                end
                return 1'b1;
            end
            q = (c == CH_SQUOTE) || (c == CH_DQUOTE);
            // A quote right after a quote is one literal quote and reopens quoting.
            if (q && quote_just_closed) begin
                add(KIND_BYTE, CH_SQUOTE);
                quoting           = 1'b1;
                quote_just_closed = 1'b0;
                label_started     = 1'b1;
                return 1'b1;
            end
            quote_just_closed = q;
            if (q) begin
                quoting = !quoting;
                return 1'b1;
            end
            if (quoting) begin
                if (c == CH_LBRACK) begin
                    commenting = 1'b1;
                end else begin
                    add(KIND_BYTE, c);
                    label_started = 1'b1;
                end
                return 1'b1;
            end
            if (c inside {CH_LPAREN, CH_RPAREN, CH_COLON, CH_COMMA}) begin
                // The label closes before ')', ':' or ',' unless the raw byte before is '('.
                if (c != CH_LPAREN && !(prev_ok && prev == CH_LPAREN)) begin
                    add(KIND_END, 8'h00);
                    label_started = 1'b0;
                end
                add(KIND_DELIM, c);
                return 1'b1;
            end
            if (c == CH_LBRACK || c == CH_RBRACK) begin
                raise_error(ERR_BRACKET);
                return 1'b0;
            end
            if (c == CH_SEMI && !at_end) begin
                raise_error((nxt == CH_NEWLINE) ? ERR_SECOND_TREE : ERR_STRAY_SEMI);
                return 1'b0;
            end
            if ((c == CH_SPACE || c == CH_NEWLINE) && label_started) begin
                raise_error(ERR_SPACE);
                return 1'b0;
            end
            add(KIND_BYTE, c);
            label_started = 1'b1;
            return 1'b1;
        endfunction

        // Work out the tokens that one accepted input byte causes.
        function void note_byte(logic [7:0] ch, logic fin);
            bit ok;
            ok = 1'b1;
            step_tokens.delete();
            if (!stopped) begin
                if (!fin) begin
                    if (held_ok) begin
                        ok = judge(held, 1'b0, ch);
                    end
                    if (ok) begin
                        if (held_ok) begin
                            prev    = held;
                            prev_ok = 1'b1;
                        end
                        held    = ch;
                        held_ok = 1'b1;
                    end
                end else if (ch == CH_NEWLINE && !held_ok) begin
                    raise_error(ERR_EMPTY);
                end else if ((ch == CH_NEWLINE && held != CH_SEMI) ||
                             (ch != CH_NEWLINE && ch != CH_SEMI)) begin
                    raise_error(ERR_NO_SEMI);
                end else begin
                    // End of text: a trailing newline is stripped.
                    if (ch == CH_NEWLINE) begin
                        ok = judge(held, 1'b1, 8'h00);
                    end else begin
                        if (held_ok) begin
                            ok = judge(held, 1'b0, ch);
                            if (ok) begin
                                prev    = held;
                                prev_ok = 1'b1;
                            end
                        end
                        if (ok) begin
                            ok = judge(ch, 1'b1, 8'h00);
                        end
                    end
                    if (ok) begin
                        if (label_started) begin
                            add(KIND_END, 8'h00);
                        end
                        clear_text();
                    end
                end
            end
            if (step_tokens.size() > 0) begin
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            end
            pending = {pending, step_tokens};
        endfunction

        // Compare one token from the block with the oldest one owed.
        function void check_token(logic [1:0] kind, logic [7:0] value, logic last);
            t_token exp;
            if (pending.size() == 0) begin
                $error("unexpected token: kind %0d, value 0x%02h, last %0d",
                       kind, value, last);
                mismatches++;
                return;
            end
            exp = pending.pop_front();
            if (exp.kind !== kind) begin
                $error("kind: expected %0d, actual %0d", exp.kind, kind);
                mismatches++;
            end
            if (exp.value !== value) begin
                $error("value: expected 0x%02h, actual 0x%02h", exp.value, value);
                mismatches++;
            end
            if (exp.last !== last) begin
                $error("run_last: expected %0d, actual %0d", exp.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;  // [7:0] ch
    logic       i_s_tlast  = 1'b0;   // final_byte
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] value
    logic [1:0] o_m_tuser;           // [1:0] kind
    logic       o_m_tlast;           // run_last

    newick_token_checker sb;
    logic [7:0]          text_q[$];
    int unsigned         idle_pct    = 0;
    int unsigned         stall_pct   = 0;
    int unsigned         cycle_count = 0;
    int unsigned         items_sent  = 0;

    newick_tokenizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock with a period of 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Token receiver: check each transfer, then stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_token(o_m_tuser, o_m_tdata, o_m_tlast);
        end
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Append one byte to the text being built.
    function automatic void put_text(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    // Any byte that is neither syntax nor a space or newline.
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b inside {CH_LPAREN, CH_RPAREN, CH_COLON, CH_COMMA, CH_LBRACK,
                             CH_RBRACK, CH_SEMI, CH_SQUOTE, CH_DQUOTE, CH_SPACE,
                             CH_NEWLINE});
        return b;
    endfunction

    // Any byte except the ones given.
    function automatic logic [7:0] pick_other(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] r;
        do begin
            r = 8'($urandom_range(255));
        end while (r == a || r == b || r == c);
        return r;
    endfunction

    function automatic void add_digits();
        repeat (1 + $urandom_range(2)) begin
            put_text(8'h30 + 8'($urandom_range(9)));  // ASCII digit
        end
    endfunction

    // Node name, optionally followed by a branch length.
    function automatic void add_name();
        logic [7:0] qc;
        case (t_name_style'($urandom_range(3)))
            NAME_PLAIN: begin
                repeat (1 + $urandom_range(2)) put_text(pick_plain());
            end
            NAME_QUOTED: begin
                qc = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                put_text(qc);
                put_text(pick_other(CH_SQUOTE, CH_DQUOTE, CH_LBRACK));
                repeat ($urandom_range(3)) begin
                    case ($urandom_range(3))
                        0: begin
                            // Comment inside quotes; its body is dropped.
                            put_text(CH_LBRACK);
                            repeat ($urandom_range(3)) begin
                                put_text(pick_other(CH_RBRACK, CH_RBRACK, CH_RBRACK));
                            end
                            put_text(CH_RBRACK);
                        end
                        1: begin
                            put_text($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE);
                            put_text($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE);
                        end
                        default: begin
                            put_text(pick_other(CH_SQUOTE, CH_DQUOTE, CH_LBRACK));
                        end
                    endcase
                end
                put_text(qc);
            end
            NAME_NUMBER: add_digits();
            default: ;
        endcase
        if ($urandom_range(1)) begin
            put_text(CH_COLON);
            add_digits();
        end
    endfunction

    // Well-formed tree body up to, but not including, the final ';'.
    function automatic void add_tree();
        int unsigned depth;
        int unsigned nodes;
        put_text(CH_LPAREN);
        depth = 1;
        nodes = 1 + $urandom_range(2);
        for (int unsigned k = 0; k < nodes; k++) begin
            while (depth < 3 && $urandom_range(2) == 0) begin
                put_text(CH_LPAREN);
                depth++;
            end
            add_name();
            while (depth > 1 && $urandom_range(2) == 0) begin
                put_text(CH_RPAREN);
                add_name();
                depth--;
            end
            if (k != nodes - 1) begin
                put_text(CH_COMMA);
            end
        end
        while (depth > 0) begin
            put_text(CH_RPAREN);
            add_name();
            depth--;
        end
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_text(s[i]);
        end
    endfunction

    // One byte transfer on the slave stream, with random idle cycles first.
    task automatic send_item(input logic [7:0] ch, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        sb.note_byte(ch, fin);
        items_sent++;
    endtask

    // Send the collected text; the last byte carries tlast if asked.
    task automatic send_text(input bit fin_last);
        for (int i = 0; i < text_q.size(); i++) begin
            send_item(text_q[i], fin_last && (i == text_q.size() - 1));
        end
        text_q.delete();
    endtask

    initial begin
        int unsigned idle_by_phase[4];
        int unsigned stall_by_phase[4];
        logic [7:0]  err;
        idle_by_phase  = '{0, 48, 0, 12};
        stall_by_phase = '{0, 0, 48, 12};
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Space at label start, doubled quote, empty labels, 0xFF, newline strip.
        push_str("( ,'a''b'):");
        put_text(8'hFF);
        push_str(";\n");
        send_text(1'b1);
        // Comment inside quotes, 0x00 in a label, text ending on ';' itself.
        push_str("\"[c]");
        put_text(8'h00);
        push_str("\",;");
        send_text(1'b1);
        // Delimiters right after '(' close no label.
        push_str("(():);");
        send_text(1'b1);

        // Random well-formed trees through the idle and stall phases.
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            while (items_sent < 28 + (p + 1) * PHASE_ITEMS) begin
                add_tree();
                put_text(CH_SEMI);
                if ($urandom_range(1)) begin
                    put_text(CH_NEWLINE);
                end
                send_text(1'b1);
            end
        end

        // One broken text at the end: the block halts until reset after it.
        err = 8'($urandom_range(ERR_SPACE));
        case (err)
            ERR_EMPTY: put_text(CH_NEWLINE);
            ERR_NO_SEMI: begin
                add_tree();
                if ($urandom_range(1)) put_text(CH_NEWLINE);
            end
            ERR_BRACKET: begin
                add_tree();
                put_text($urandom_range(1) ? CH_LBRACK : CH_RBRACK);
                put_text(pick_plain());
            end
            ERR_SECOND_TREE: begin
                add_tree();
                put_text(CH_SEMI);
                put_text(CH_NEWLINE);
            end
            ERR_STRAY_SEMI: begin
                add_tree();
                put_text(CH_SEMI);
                put_text(pick_plain());
            end
            default: begin
                add_tree();
                put_text(pick_plain());
                put_text($urandom_range(1) ? CH_SPACE : CH_NEWLINE);
                put_text(pick_plain());
            end
        endcase
        send_text(err == ERR_EMPTY || err == ERR_NO_SEMI);
        // Bytes after the error must be swallowed.
        repeat (5) begin
            send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        i_s_tvalid <= 1'b0;
        stall_pct = 0;

        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("newick_tokenizer test passed");
        end else begin
            $display("newick_tokenizer test failed");
        end
        $finish;
    end

    // Timeout.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("newick_tokenizer test failed");
        $finish;
    end

endmodule
